### sv/bounding_box_tracker_3d_macros.svh
// Assertion macros for the bounding box tracker.
`ifndef BOUNDING_BOX_TRACKER_3D_MACROS_SVH
`define BOUNDING_BOX_TRACKER_3D_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define BBT_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bbt assertion failed");

// Next-cycle implication, disabled while reset is active.
`define BBT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bbt assertion failed");

`endif

### sv/bbt_pkg.sv
`default_nettype none

package bbt_pkg;

    typedef logic signed [31:0] coord_t;

    localparam logic REQ_CLEAR = 1'b0;
    localparam logic REQ_ADD   = 1'b1;

    localparam coord_t BOX_INIT_POS = 32'sd2560000;
    localparam coord_t BOX_INIT_NEG = -32'sd2560000;
    localparam logic [32:0] TWO_Q   = 33'd512;
    localparam logic [30:0] ONE_Q   = 31'd256;
    localparam logic [30:0] EMPTY_HALF = 31'd2560000;

    typedef struct packed {
        logic          req_type;
        logic signed [31:0] x_coord;
        logic signed [31:0] y_coord;
        logic signed [31:0] z_coord;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] lo_x;
        logic signed [31:0] lo_y;
        logic signed [31:0] lo_z;
        logic signed [31:0] hi_x;
        logic signed [31:0] hi_y;
        logic signed [31:0] hi_z;
        logic signed [31:0] mid_x;
        logic signed [31:0] mid_y;
        logic signed [31:0] mid_z;
        logic [30:0]        half_longest;
        logic               box_empty;
    } out_item_t;

    // Index 0 is x, 1 is y, 2 is z.
    typedef struct packed {
        coord_t [2:0] lo;
        coord_t [2:0] hi;
        logic         empty;
    } box_t;

endpackage

`default_nettype wire

### sv/bounding_box_tracker_3d.sv
`default_nettype none

// 3D axis-aligned bounding box tracker. Each input transaction either clears
// the box (req_type 0) or adds one Q23.8 vertex (req_type 1), and produces
// exactly one result transaction with both corners, the centre, the empty
// flag and half the longest extent (at least 1.0) after the update. The block takes one
// transaction per clock cycle while the result channel is not stalled; a result is presented
// after its input has passed the input, corner update and result registers.
// The rate is set by the per-axis min/max update, which is combinational.
// Back-pressure on the result channel stalls the pipeline without loss.
module bounding_box_tracker_3d (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire bbt_pkg::in_item_t s_item,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output bbt_pkg::out_item_t     m_item
);

    logic               box_valid;
    bbt_pkg::box_t      box;
    bbt_pkg::out_item_t result;
    logic               m_valid_reg;
    bbt_pkg::out_item_t m_item_reg;
    logic               out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;

    bbt_corner_unit u_corner (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .box_take  (out_free),
        .box_valid (box_valid),
        .box       (box)
    );

    bbt_result_calc u_calc (
        .box    (box),
        .result (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= box_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && box_valid) begin
            m_item_reg <= result;
        end
    end

`include "bounding_box_tracker_3d_macros.svh"

    `BBT_ASSERT_NOW(a_empty_is_sentinel, aclk, aresetn, m_valid && m_item.box_empty,
        m_item.half_longest == bbt_pkg::EMPTY_HALF && m_item.mid_x == 32'sd0)
    `BBT_ASSERT_NOW(a_filled_ordered, aclk, aresetn, m_valid && !m_item.box_empty,
        $signed(m_item.lo_x) <= $signed(m_item.hi_x)
        && $signed(m_item.lo_z) <= $signed(m_item.hi_z))
    `BBT_ASSERT_NOW(a_half_floor, aclk, aresetn, m_valid,
        m_item.half_longest >= bbt_pkg::ONE_Q)
    `BBT_ASSERT_NEXT(a_clear_reaches_box, aclk, aresetn,
        u_corner.in_adv && u_corner.in_reg.req_type == bbt_pkg::REQ_CLEAR, box.empty)

endmodule

`default_nettype wire

### sv/bbt_corner_unit.sv
`default_nettype none

module bbt_corner_unit (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire bbt_pkg::in_item_t s_item,
    input  wire logic            box_take,
    output logic                 box_valid,
    output bbt_pkg::box_t        box
);

    logic              in_valid_reg;
    bbt_pkg::in_item_t in_reg;
    logic              box_valid_reg;
    bbt_pkg::box_t     box_reg;
    bbt_pkg::box_t     box_next;
    bbt_pkg::coord_t [2:0] coord;
    logic              box_free;
    logic              in_adv;

    assign box_free  = !box_valid_reg || box_take;
    assign in_adv    = in_valid_reg && box_free;
    assign s_ready   = !in_valid_reg || box_free;
    assign box_valid = box_valid_reg;
    assign box       = box_reg;

    assign coord[0] = in_reg.x_coord;
    assign coord[1] = in_reg.y_coord;
    assign coord[2] = in_reg.z_coord;

    always_comb begin
        box_next = box_reg;
        if (in_reg.req_type == bbt_pkg::REQ_ADD) begin
            for (int i = 0; i < 3; i++) begin
                if ($signed(coord[i]) < $signed(box_reg.lo[i])) begin
                    box_next.lo[i] = coord[i];
                end
                if ($signed(coord[i]) > $signed(box_reg.hi[i])) begin
                    box_next.hi[i] = coord[i];
                end
            end
            box_next.empty = 1'b0;
        end else begin
            for (int i = 0; i < 3; i++) begin
                box_next.lo[i] = bbt_pkg::BOX_INIT_POS;
                box_next.hi[i] = bbt_pkg::BOX_INIT_NEG;
            end
            box_next.empty = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            box_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                box_reg.lo[i] <= bbt_pkg::BOX_INIT_POS;
                box_reg.hi[i] <= bbt_pkg::BOX_INIT_NEG;
            end
            box_reg.empty <= 1'b1;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (box_free) begin
                box_valid_reg <= in_valid_reg;
            end
            if (in_adv) begin
                box_reg <= box_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_item;
        end
    end

endmodule

`default_nettype wire

### sv/bbt_result_calc.sv
`default_nettype none

module bbt_result_calc (
    input  wire bbt_pkg::box_t  box,
    output bbt_pkg::out_item_t result
);

    logic signed [32:0] ext [3];
    logic signed [32:0] sum [3];
    logic signed [32:0] max01;
    logic signed [32:0] size;
    logic [32:0]        mag;
    logic [30:0]        half;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ext[i] = {box.hi[i][31], box.hi[i]} - {box.lo[i][31], box.lo[i]};
            sum[i] = {box.lo[i][31], box.lo[i]} + {box.hi[i][31], box.hi[i]};
        end
        max01 = (ext[0] > ext[1]) ? ext[0] : ext[1];
        size  = (max01 > ext[2]) ? max01 : ext[2];
        mag   = size[32] ? 33'(-size) : 33'(size);
        half  = (mag >= bbt_pkg::TWO_Q) ? mag[31:1] : bbt_pkg::ONE_Q;
    end

    assign result.lo_x         = box.lo[0];
    assign result.lo_y         = box.lo[1];
    assign result.lo_z         = box.lo[2];
    assign result.hi_x         = box.hi[0];
    assign result.hi_y         = box.hi[1];
    assign result.hi_z         = box.hi[2];
    assign result.mid_x        = sum[0][32:1];
    assign result.mid_y        = sum[1][32:1];
    assign result.mid_z        = sum[2][32:1];
    assign result.half_longest = half;
    assign result.box_empty    = box.empty;

endmodule

`default_nettype wire
